// File: rtl/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types and constants for the Sobel edge magnitude core.
// ----------------------------------------------------------------------------
package sobel_pkg;

    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 12;
    localparam logic [CfgIdxW-1:0] REG_FRAME_COLS = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_FRAME_ROWS = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_THRESHOLD  = 2'd2;

    // window mode
    localparam logic MODE_UPPER = 1'b0;
    localparam logic MODE_LAST  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQUARE,
        ST_ROOT,
        ST_OUT
    } sobel_state_t;

    // controller to datapath
    typedef struct packed {
        logic       accept;     // latch pixel, read line buffers
        logic       load_win;   // update window and write line buffers
        logic       mode;
        logic       right_dup;  // right column duplicates centre
        logic       col_prev;   // result column is c-1
        logic       row_prev;   // result row is r-1
        logic       square;     // compute squares
        logic       root_step;  // one root iteration
        logic       advance;    // update position counters
    } sobel_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       row_ge1;
        logic       col_ge1;
        logic       row_end;
        logic       last_row;
        logic       root_done;
    } sobel_status_t;

endpackage

// File: rtl/sobel_ctrl.sv
// ----------------------------------------------------------------------------
// sobel_ctrl
// Sequencer: per pixel, walks the list of pending results.
// ----------------------------------------------------------------------------
module sobel_ctrl
    import sobel_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_last,
    input  sobel_status_t status,
    output sobel_cmd_t    cmd
);

    sobel_state_t state_reg, state_next;
    logic [3:0]   pend_reg, pend_next;    // remaining results of this pixel
    logic [3:0]   cur_reg, cur_next;      // one-hot current result

    // pending results from status
    logic [3:0] pend_init;
    always_comb begin
        pend_init[0] = status.row_ge1 && status.col_ge1;
        pend_init[1] = status.row_ge1 && status.row_end;
        pend_init[2] = status.last_row && status.col_ge1;
        pend_init[3] = status.last_row && status.row_end;
    end

    // lowest set bit
    function automatic logic [3:0] low_bit(input logic [3:0] v);
        logic [3:0] r;
        r = 4'd0;
        if (v[0])      r = 4'b0001;
        else if (v[1]) r = 4'b0010;
        else if (v[2]) r = 4'b0100;
        else if (v[3]) r = 4'b1000;
        return r;
    endfunction

    logic [3:0] rest;
    assign rest = pend_reg & ~cur_reg;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 4'd0;
            cur_reg   <= 4'd0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            cur_reg   <= cur_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cur_next   = cur_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        m_last     = 1'b0;
        cmd.mode      = (cur_reg[2] || cur_reg[3]) ? MODE_LAST : MODE_UPPER;
        cmd.right_dup = cur_reg[1] || cur_reg[3];
        cmd.col_prev  = cur_reg[0] || cur_reg[2];
        cmd.row_prev  = cur_reg[0] || cur_reg[1];
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load_win = 1'b1;
                pend_next    = pend_init;
                cur_next     = low_bit(pend_init);
                if (pend_init == 4'd0) begin
                    cmd.advance = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (status.root_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                m_last  = (rest == 4'd0);
                if (m_ready) begin
                    pend_next = rest;
                    cur_next  = low_bit(rest);
                    if (rest == 4'd0) begin
                        cmd.advance = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        state_next = ST_SQUARE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // one result at a time, drawn from pending set
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQUARE) |-> $onehot(cur_reg) && ((cur_reg & pend_reg) != 4'd0))
        else $error("current result not pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_ready && m_valid) == 1'b0)
        else $error("accept during output");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !m_ready) |=> (state_reg == ST_OUT))
        else $error("output dropped");

endmodule

// File: rtl/sobel_datapath.sv
// ----------------------------------------------------------------------------
// sobel_datapath
// Line buffers, window, position counters, gradient and bit-serial root.
// ----------------------------------------------------------------------------
module sobel_datapath
    import sobel_pkg::*;
#(
    parameter int MAX_COLS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           s_pixel,
    input  logic                 cfg_wr_en,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data,
    input  sobel_cmd_t           cmd,
    output sobel_status_t        status,
    output logic [11:0]          m_out_row,
    output logic [9:0]           m_out_col,
    output logic [7:0]           m_magnitude
);

    localparam int AW = $clog2(MAX_COLS);
    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int GW = 12;

    // configuration
    logic [CW-1:0] frame_cols_reg;
    logic [11:0]   frame_rows_reg;
    logic [7:0]    thresh_reg;
    logic [CW-1:0] row_count_c;
    logic [AW-1:0] col_reg;
    logic [11:0]   row_reg;

    logic [10:0] cols_in;
    logic [11:0] rows_in;
    assign cols_in = cfg_data[10:0];
    assign rows_in = cfg_data[11:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_cols_reg <= (1024 > MAX_COLS) ? CW'(MAX_COLS) : CW'(1024);
            frame_rows_reg <= 12'd768;
            thresh_reg     <= 8'd25;
            col_reg        <= '0;
            row_reg        <= '0;
        end else begin
            if (cfg_wr_en && cfg_index == REG_FRAME_COLS) begin
                if (cols_in == 11'd0)
                    frame_cols_reg <= CW'(1);
                else if ({21'd0, cols_in} > 32'(MAX_COLS))
                    frame_cols_reg <= CW'(MAX_COLS);
                else
                    frame_cols_reg <= CW'(cols_in);
                col_reg <= '0;
                row_reg <= '0;
            end else if (cfg_wr_en && cfg_index == REG_FRAME_ROWS) begin
                frame_rows_reg <= (rows_in == 12'd0) ? 12'd1 : rows_in;
                col_reg <= '0;
                row_reg <= '0;
            end else if (cmd.advance) begin
                if (status.row_end) begin
                    col_reg <= '0;
                    row_reg <= status.last_row ? 12'd0 : row_reg + 12'd1;
                end else begin
                    col_reg <= col_reg + AW'(1);
                end
            end
            if (cfg_wr_en && cfg_index == REG_THRESHOLD)
                thresh_reg <= cfg_data[7:0];
        end
    end
    assign row_count_c = CW'(col_reg) + CW'(1);

    // position flags
    assign status.row_end  = (row_count_c >= frame_cols_reg);
    assign status.last_row = ({1'b0, row_reg} + 13'd1 >= {1'b0, frame_rows_reg});
    assign status.row_ge1  = (row_reg != 12'd0);
    assign status.col_ge1  = (col_reg != '0);

    // line buffers
    logic [7:0] line_above_mem [MAX_COLS];
    logic [7:0] line_two_mem   [MAX_COLS];
    logic [7:0] above_rd_reg, two_rd_reg, pix_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            above_rd_reg <= line_above_mem[col_reg];
            two_rd_reg   <= line_two_mem[col_reg];
            pix_reg      <= s_pixel;
        end
        if (cmd.load_win) begin
            line_two_mem[col_reg]   <= above_rd_reg;
            line_above_mem[col_reg] <= pix_reg;
        end
    end

    // window: [column][row]
    logic [7:0] win_reg [3][3];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++)
                for (int j = 0; j < 3; j++)
                    win_reg[k][j] <= 8'd0;
        end else if (cmd.load_win) begin
            for (int k = 0; k < 3; k++) begin
                if (col_reg == '0 || k == 2) begin
                    win_reg[k][0] <= two_rd_reg;
                    win_reg[k][1] <= above_rd_reg;
                    win_reg[k][2] <= pix_reg;
                end else begin
                    win_reg[k][0] <= win_reg[k+1][0];
                    win_reg[k][1] <= win_reg[k+1][1];
                    win_reg[k][2] <= win_reg[k+1][2];
                end
            end
        end
    end

    // clamped column values
    logic [7:0] lv [3], cv [3], rv [3];
    logic       r_is1, r_is0;
    assign r_is1 = (row_reg == 12'd1);
    assign r_is0 = (row_reg == 12'd0);

    function automatic logic [23:0] col_rows(input logic [7:0] t, input logic [7:0] m,
                                             input logic [7:0] b, input logic md,
                                             input logic one, input logic zero);
        logic [7:0] v0, v1, v2;
        if (md == MODE_UPPER) begin
            v0 = one ? m : t; v1 = m; v2 = b;
        end else begin
            v0 = zero ? b : m; v1 = b; v2 = b;
        end
        return {v0, v1, v2};
    endfunction

    always_comb begin
        if (cmd.right_dup) begin
            {lv[0], lv[1], lv[2]} = col_rows(win_reg[1][0], win_reg[1][1], win_reg[1][2],
                                             cmd.mode, r_is1, r_is0);
            {cv[0], cv[1], cv[2]} = col_rows(win_reg[2][0], win_reg[2][1], win_reg[2][2],
                                             cmd.mode, r_is1, r_is0);
        end else begin
            {lv[0], lv[1], lv[2]} = col_rows(win_reg[0][0], win_reg[0][1], win_reg[0][2],
                                             cmd.mode, r_is1, r_is0);
            {cv[0], cv[1], cv[2]} = col_rows(win_reg[1][0], win_reg[1][1], win_reg[1][2],
                                             cmd.mode, r_is1, r_is0);
        end
        {rv[0], rv[1], rv[2]} = col_rows(win_reg[2][0], win_reg[2][1], win_reg[2][2],
                                         cmd.mode, r_is1, r_is0);
    end

    // gradients
    logic signed [GW-1:0] gx, gy;
    always_comb begin
        gx = $signed({2'b0, rv[0]}) + $signed({1'b0, rv[1], 1'b0}) + $signed({2'b0, rv[2]})
           - $signed({2'b0, lv[0]}) - $signed({1'b0, lv[1], 1'b0}) - $signed({2'b0, lv[2]});
        gy = $signed({2'b0, lv[2]}) + $signed({1'b0, cv[2], 1'b0}) + $signed({2'b0, rv[2]})
           - $signed({2'b0, lv[0]}) - $signed({1'b0, cv[0], 1'b0}) - $signed({2'b0, rv[0]});
    end

    // squared sum and bit-serial root
    logic [20:0] sum_reg;
    logic [7:0]  root_reg;
    logic [7:0]  bit_reg;
    logic [11:0] ax, ay;
    assign ax = gx[GW-1] ? 12'(-gx) : 12'(gx);
    assign ay = gy[GW-1] ? 12'(-gy) : 12'(gy);

    logic [7:0]  trial;
    logic [15:0] trial_sq;
    assign trial    = root_reg | bit_reg;
    assign trial_sq = trial * trial;

    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            sum_reg   <= 21'(ax) * 21'(ax) + 21'(ay) * 21'(ay);
            root_reg  <= 8'd0;
            bit_reg   <= 8'h80;
            m_out_row <= cmd.row_prev ? row_reg - 12'd1 : row_reg;
            m_out_col <= 10'(cmd.col_prev ? col_reg - AW'(1) : col_reg);
        end else if (cmd.root_step) begin
            if ({5'd0, trial_sq} <= sum_reg) root_reg <= trial;
            bit_reg <= bit_reg >> 1;
        end
    end
    assign status.root_done = (bit_reg == 8'd1);

    // saturate then threshold
    logic [7:0] mag;
    assign mag = (sum_reg >= 21'd65536) ? 8'd255 : root_reg;
    assign m_magnitude = (mag < thresh_reg) ? 8'd0 : mag;

    // root squared never exceeds the sum
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.root_step |=> ({5'd0, 16'(root_reg) * 16'(root_reg)} <= sum_reg))
        else $error("root overshoot");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg < AW'(MAX_COLS - 1)) || (col_reg == AW'(MAX_COLS - 1)))
        else $error("column out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.square |=> $onehot(bit_reg))
        else $error("root bit not one-hot");

endmodule

// File: rtl/sobel_edge_magnitude_threshold_core.sv
// Sequence: after a pixel is accepted the core loads the window, then squares the
// gradients and runs 8 root steps per result of that pixel, one result after another.
// Flow: no new pixel is taken until every result of the current pixel has been
// accepted downstream, so output stalls hold the input; the root is bit-serial.
// Reset: synchronous active-low; configuration, window and state registers return to their
// defaults and the frame restarts at row 0, column 0. Line buffers are not cleared.
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_threshold_core
// Streaming 3x3 Sobel magnitude with threshold and frame border replication.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_threshold_core
    import sobel_pkg::*;
#(
    parameter int MAX_COLS = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_pixel,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [11:0]         m_out_row,
    output logic [9:0]          m_out_col,
    output logic [7:0]          m_magnitude,
    output logic                m_last_of_item
);

    sobel_cmd_t    cmd;
    sobel_status_t status;

    sobel_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_last  (m_last_of_item),
        .status  (status),
        .cmd     (cmd)
    );

    sobel_datapath #(.MAX_COLS(MAX_COLS)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_pixel     (s_pixel),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_magnitude (m_magnitude)
    );

endmodule
